FILE: design/wmsm_pkg.sv
// Shared constants, codes and helpers of the windowed mailbox slot manager.
package wmsm_pkg;

  localparam int NUM_KINDS   = 3;
  localparam int KIND_W      = 2;
  localparam int SEQ_W       = 64;
  localparam int OFF_W       = 30;
  localparam int WIN_W       = 11;
  localparam int SLOT_W      = 21;
  localparam int REM_W       = 10;
  localparam int DLEN_W      = 20;
  localparam int PROD_W      = SLOT_W + REM_W;
  localparam int GUARD_BYTES = 8;

  // Remainder unit: RADIX_BITS dividend bits retired per cycle
  localparam int RADIX_BITS  = 4;
  localparam int DIV_STEPS   = SEQ_W / RADIX_BITS;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam int IDX_W       = 3;
  localparam int IN_DATA_W   = 4 * SEQ_W;
  localparam int IN_USER_W   = 4;
  localparam int OUT_DATA_W  = 304;
  localparam int OUT_USER_W  = 4;

  typedef logic [KIND_W-1:0] kind_t;

  localparam logic [1:0] REQ_CLAIM   = 2'd0;
  localparam logic [1:0] REQ_PROBE   = 2'd1;
  localparam logic [1:0] REQ_CONSUME = 2'd2;
  localparam logic [1:0] REQ_LOCATE  = 2'd3;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_NONE = 2'd2;

  localparam kind_t KIND_REPLY   = 2'd0;
  localparam kind_t KIND_REQUEST = 2'd1;
  localparam kind_t KIND_RPC     = 2'd2;

  localparam logic [IDX_W-1:0] CFG_WIN_REPLY    = 3'd0;
  localparam logic [IDX_W-1:0] CFG_WIN_REQUEST  = 3'd1;
  localparam logic [IDX_W-1:0] CFG_WIN_RPC      = 3'd2;
  localparam logic [IDX_W-1:0] CFG_SLOT_REPLY   = 3'd3;
  localparam logic [IDX_W-1:0] CFG_SLOT_REQUEST = 3'd4;
  localparam logic [IDX_W-1:0] CFG_SLOT_RPC     = 3'd5;

  localparam logic [WIN_W-1:0]  WIN_MIN    = 11'd1;
  localparam logic [WIN_W-1:0]  WIN_MAX    = 11'd1024;
  localparam logic [WIN_W-1:0]  WIN_RESET  = 11'd16;
  localparam logic [SLOT_W-1:0] SLOT_MIN   = 21'd16;
  localparam logic [SLOT_W-1:0] SLOT_MAX   = 21'd1048576;
  localparam logic [SLOT_W-1:0] SLOT_RESET = 21'd4096;

  function automatic logic [WIN_W-1:0] win_clamp(logic [WIN_W-1:0] v);
    logic [WIN_W-1:0] r;
    r = v;
    if (v < WIN_MIN) r = WIN_MIN;
    else if (v > WIN_MAX) r = WIN_MAX;
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_clamp(logic [SLOT_W-1:0] v);
    logic [SLOT_W-1:0] r;
    r = v;
    if (v < SLOT_MIN) r = SLOT_MIN;
    else if (v > SLOT_MAX) r = SLOT_MAX;
    return r;
  endfunction

endpackage

FILE: design/windowed_mailbox_slot_manager_core.sv
// Windowed mailbox slot manager: counters, sequencer and shared remainder unit.
// A probe checks guard words in turn; a refused claim or a probe that finds nothing
// computes only the expected guard offsets and skips the served slot.
// Each slot offset is a pass: load, remainder steps at 4 bits each, mul, add.
// Items are taken one at a time, only while idle; a held result stalls the finish.
// Reset clears counters and returns window and slot registers to 16 and 4096.
module windowed_mailbox_slot_manager_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wmsm_pkg::IDX_W-1:0]          cfg_idx_i,
  input  logic [wmsm_pkg::SLOT_W-1:0]         cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // seq_in, guard_reply, guard_request, guard_rpc
  input  logic [wmsm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // req_type, msg_kind
  input  logic [wmsm_pkg::IN_USER_W-1:0]      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // data_offset, guard_offset, seq_out, guard_value, data_length,
  // expect_off_reply, expect_off_request, expect_off_rpc, zero pad
  output logic [wmsm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // status, found_kind
  output logic [wmsm_pkg::OUT_USER_W-1:0]     m_axis_tuser
);

  localparam int SW = wmsm_pkg::SEQ_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECIDE, ST_PROBE, ST_LOAD, ST_DIV, ST_MUL, ST_OFF, ST_DONE
  } state_e;

  state_e state_q;

  // Configuration
  logic [wmsm_pkg::WIN_W-1:0]  win_reply_q, win_request_q, win_rpc_q;
  logic [wmsm_pkg::SLOT_W-1:0] slot_reply_q, slot_request_q, slot_rpc_q;

  // Counters
  logic [wmsm_pkg::NUM_KINDS-1:0][SW-1:0] in_cnt_q;
  logic [wmsm_pkg::NUM_KINDS-1:0][SW-1:0] out_cnt_q;

  // Captured item
  logic [1:0]            req_q;
  wmsm_pkg::kind_t       kind_q;
  logic [SW-1:0]         seq_in_q, g_reply_q, g_request_q, g_rpc_q;

  // Result staging
  logic [1:0]                       status_q;
  wmsm_pkg::kind_t                  fk_q;
  wmsm_pkg::kind_t                  main_kind_q;
  logic [wmsm_pkg::OFF_W-1:0]       doff_q, goff_q;
  logic [SW-1:0]                    seq_q, gval_q;
  logic [wmsm_pkg::DLEN_W-1:0]      dlen_q;
  logic [wmsm_pkg::NUM_KINDS-1:0][wmsm_pkg::OFF_W-1:0] exp_q;

  // Sequencer and remainder unit
  wmsm_pkg::kind_t                  pidx_q;
  logic [1:0]                       job_q;
  logic [SW-1:0]                    div_q;
  logic [wmsm_pkg::REM_W-1:0]       rem_q, rem_d;
  logic [wmsm_pkg::STEP_W-1:0]      cnt_q;
  logic [wmsm_pkg::PROD_W-1:0]      prod_q;

  // Output register
  logic                                 m_valid_q;
  logic [wmsm_pkg::OUT_DATA_W-1:0]      m_data_q;
  logic [wmsm_pkg::OUT_USER_W-1:0]      m_user_q;

  logic                             in_xfer;
  wmsm_pkg::kind_t                  kind_clip;
  wmsm_pkg::kind_t                  jk;
  logic [wmsm_pkg::WIN_W-1:0]       jwin, req_win;
  logic [wmsm_pkg::SLOT_W-1:0]      jslot, kslot, pslot;
  logic [SW-1:0]                    gsel, pcnt_inc, kdiv;
  logic                             pmatch, claim_ok;
  logic [wmsm_pkg::PROD_W:0]        gsum;
  logic [wmsm_pkg::SLOT_W-1:0]      jslot_m8;
  logic [wmsm_pkg::WIN_W-1:0]       trial;
  logic [wmsm_pkg::REM_W-1:0]       rwork;

  function automatic logic [wmsm_pkg::WIN_W-1:0] sel_win(
    wmsm_pkg::kind_t k, logic [wmsm_pkg::WIN_W-1:0] w0,
    logic [wmsm_pkg::WIN_W-1:0] w1, logic [wmsm_pkg::WIN_W-1:0] w2);
    logic [wmsm_pkg::WIN_W-1:0] r;
    case (k)
      wmsm_pkg::KIND_REPLY:   r = w0;
      wmsm_pkg::KIND_REQUEST: r = w1;
      default:                r = w2;
    endcase
    return wmsm_pkg::win_clamp(r);
  endfunction

  function automatic logic [wmsm_pkg::SLOT_W-1:0] sel_slot(
    wmsm_pkg::kind_t k, logic [wmsm_pkg::SLOT_W-1:0] s0,
    logic [wmsm_pkg::SLOT_W-1:0] s1, logic [wmsm_pkg::SLOT_W-1:0] s2);
    logic [wmsm_pkg::SLOT_W-1:0] r;
    case (k)
      wmsm_pkg::KIND_REPLY:   r = s0;
      wmsm_pkg::KIND_REQUEST: r = s1;
      default:                r = s2;
    endcase
    return wmsm_pkg::slot_clamp(r);
  endfunction

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  always_comb begin
    if (s_axis_tuser[3:2] >= wmsm_pkg::KIND_W'(wmsm_pkg::NUM_KINDS))
      kind_clip = wmsm_pkg::KIND_W'(wmsm_pkg::NUM_KINDS - 1);
    else
      kind_clip = s_axis_tuser[3:2];
  end

  // Job 0 is the served slot, jobs 1..NUM_KINDS the expected guard offsets
  assign jk = (job_q == 2'd0) ? main_kind_q : wmsm_pkg::KIND_W'(job_q - 2'd1);
  assign jwin    = sel_win(jk, win_reply_q, win_request_q, win_rpc_q);
  assign req_win = sel_win(wmsm_pkg::KIND_REQUEST, win_reply_q, win_request_q, win_rpc_q);
  assign jslot   = sel_slot(jk, slot_reply_q, slot_request_q, slot_rpc_q);
  assign kslot   = sel_slot(kind_q, slot_reply_q, slot_request_q, slot_rpc_q);
  assign pslot   = sel_slot(pidx_q, slot_reply_q, slot_request_q, slot_rpc_q);
  assign kdiv    = (job_q == 2'd0) ? seq_q : in_cnt_q[jk];

  always_comb begin
    case (pidx_q)
      wmsm_pkg::KIND_REPLY:   gsel = g_reply_q;
      wmsm_pkg::KIND_REQUEST: gsel = g_request_q;
      default:                gsel = g_rpc_q;
    endcase
  end

  assign pcnt_inc = in_cnt_q[pidx_q] + SW'(1);
  assign pmatch   = (gsel == pcnt_inc);
  assign claim_ok = (out_cnt_q[wmsm_pkg::KIND_REQUEST] - in_cnt_q[wmsm_pkg::KIND_REPLY])
                    < SW'(req_win);

  // Restoring remainder, RADIX_BITS dividend bits per cycle
  always_comb begin
    rwork = rem_q;
    trial = '0;
    for (int j = 0; j < wmsm_pkg::RADIX_BITS; j++) begin
      trial = {rwork, div_q[SW-1-j]};
      if (trial >= jwin) trial = trial - jwin;
      rwork = trial[wmsm_pkg::REM_W-1:0];
    end
    rem_d = rwork;
  end

  assign jslot_m8 = jslot - wmsm_pkg::SLOT_W'(wmsm_pkg::GUARD_BYTES);
  assign gsum     = {1'b0, prod_q} + (wmsm_pkg::PROD_W + 1)'(jslot_m8);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      m_valid_q      <= 1'b0;
      win_reply_q    <= wmsm_pkg::WIN_RESET;
      win_request_q  <= wmsm_pkg::WIN_RESET;
      win_rpc_q      <= wmsm_pkg::WIN_RESET;
      slot_reply_q   <= wmsm_pkg::SLOT_RESET;
      slot_request_q <= wmsm_pkg::SLOT_RESET;
      slot_rpc_q     <= wmsm_pkg::SLOT_RESET;
      in_cnt_q       <= '0;
      out_cnt_q      <= '0;
      job_q          <= '0;
      pidx_q         <= '0;
      cnt_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          wmsm_pkg::CFG_WIN_REPLY:    win_reply_q    <= cfg_data_i[wmsm_pkg::WIN_W-1:0];
          wmsm_pkg::CFG_WIN_REQUEST:  win_request_q  <= cfg_data_i[wmsm_pkg::WIN_W-1:0];
          wmsm_pkg::CFG_WIN_RPC:      win_rpc_q      <= cfg_data_i[wmsm_pkg::WIN_W-1:0];
          wmsm_pkg::CFG_SLOT_REPLY:   slot_reply_q   <= cfg_data_i;
          wmsm_pkg::CFG_SLOT_REQUEST: slot_request_q <= cfg_data_i;
          wmsm_pkg::CFG_SLOT_RPC:     slot_rpc_q     <= cfg_data_i;
          default: ;
        endcase
      end

      // Load a finished result, else drop valid once the transfer is taken
      if (state_q == ST_DONE && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            req_q       <= s_axis_tuser[1:0];
            kind_q      <= kind_clip;
            seq_in_q    <= s_axis_tdata[SW-1:0];
            g_reply_q   <= s_axis_tdata[2*SW-1:SW];
            g_request_q <= s_axis_tdata[3*SW-1:2*SW];
            g_rpc_q     <= s_axis_tdata[4*SW-1:3*SW];
            state_q     <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          fk_q        <= kind_q;
          main_kind_q <= kind_q;
          doff_q      <= '0;
          goff_q      <= '0;
          dlen_q      <= wmsm_pkg::DLEN_W'(kslot - wmsm_pkg::SLOT_W'(wmsm_pkg::GUARD_BYTES));
          case (req_q)
            wmsm_pkg::REQ_CLAIM: begin
              state_q <= ST_LOAD;
              if (kind_q == wmsm_pkg::KIND_REQUEST && !claim_ok) begin
                status_q <= wmsm_pkg::STAT_FULL;
                seq_q    <= '0;
                gval_q   <= '0;
                job_q    <= 2'd1;
              end else begin
                status_q          <= wmsm_pkg::STAT_DONE;
                seq_q             <= out_cnt_q[kind_q];
                gval_q            <= out_cnt_q[kind_q] + SW'(1);
                out_cnt_q[kind_q] <= out_cnt_q[kind_q] + SW'(1);
                job_q             <= 2'd0;
              end
            end
            wmsm_pkg::REQ_PROBE: begin
              status_q <= wmsm_pkg::STAT_DONE;
              seq_q    <= '0;
              gval_q   <= '0;
              pidx_q   <= '0;
              state_q  <= ST_PROBE;
            end
            wmsm_pkg::REQ_CONSUME: begin
              status_q         <= wmsm_pkg::STAT_DONE;
              seq_q            <= in_cnt_q[kind_q];
              gval_q           <= in_cnt_q[kind_q] + SW'(1);
              in_cnt_q[kind_q] <= in_cnt_q[kind_q] + SW'(1);
              job_q            <= 2'd0;
              state_q          <= ST_LOAD;
            end
            default: begin
              status_q <= wmsm_pkg::STAT_DONE;
              seq_q    <= seq_in_q;
              gval_q   <= seq_in_q + SW'(1);
              job_q    <= 2'd0;
              state_q  <= ST_LOAD;
            end
          endcase
        end
        ST_PROBE: begin
          // Check kinds in order, first guard hit wins
          if (pmatch) begin
            fk_q        <= pidx_q;
            main_kind_q <= pidx_q;
            seq_q       <= in_cnt_q[pidx_q];
            gval_q      <= gsel;
            dlen_q      <= wmsm_pkg::DLEN_W'(pslot - wmsm_pkg::SLOT_W'(wmsm_pkg::GUARD_BYTES));
            job_q       <= 2'd0;
            state_q     <= ST_LOAD;
          end else if (pidx_q == wmsm_pkg::KIND_W'(wmsm_pkg::NUM_KINDS - 1)) begin
            status_q <= wmsm_pkg::STAT_NONE;
            fk_q     <= '0;
            dlen_q   <= '0;
            job_q    <= 2'd1;
            state_q  <= ST_LOAD;
          end else begin
            pidx_q <= pidx_q + wmsm_pkg::KIND_W'(1);
          end
        end
        ST_LOAD: begin
          div_q   <= kdiv;
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q <= rem_d;
          div_q <= {div_q[SW-1-wmsm_pkg::RADIX_BITS:0], {wmsm_pkg::RADIX_BITS{1'b0}}};
          cnt_q <= cnt_q + wmsm_pkg::STEP_W'(1);
          if (cnt_q == wmsm_pkg::STEP_W'(wmsm_pkg::DIV_STEPS - 1)) state_q <= ST_MUL;
        end
        ST_MUL: begin
          prod_q  <= wmsm_pkg::PROD_W'(jslot) * wmsm_pkg::PROD_W'(rem_q);
          state_q <= ST_OFF;
        end
        ST_OFF: begin
          if (job_q == 2'd0) begin
            doff_q <= prod_q[wmsm_pkg::OFF_W-1:0];
            goff_q <= gsum[wmsm_pkg::OFF_W-1:0];
          end else begin
            exp_q[jk] <= gsum[wmsm_pkg::OFF_W-1:0];
          end
          if (job_q == 2'(wmsm_pkg::NUM_KINDS)) begin
            state_q <= ST_DONE;
          end else begin
            job_q   <= job_q + 2'd1;
            state_q <= ST_LOAD;
          end
        end
        ST_DONE: begin
          // Wait for the output register to drain
          if (!m_valid_q || m_axis_tready) begin
            m_user_q  <= {fk_q, status_q};
            m_data_q  <= {6'b0, exp_q[2], exp_q[1], exp_q[0], dlen_q, gval_q, seq_q,
                          goff_q, doff_q};
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_rem_below_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> (wmsm_pkg::WIN_W'(rem_q) < jwin))
    else $error("remainder not below window");

  a_accept_starts_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == ST_DECIDE)
    else $error("accepted item did not start");

  a_counters_only_in_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_DECIDE |=> $stable(in_cnt_q) && $stable(out_cnt_q))
    else $error("counter moved outside decide step");

  a_full_only_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_user_q[1:0] == wmsm_pkg::STAT_FULL |->
      m_user_q[3:2] == wmsm_pkg::KIND_REQUEST)
    else $error("window full reported for a reply kind");
`endif

endmodule
